>>> rtl/timestamped_message_delay_queue_macros.svh
// ----------------------------------------------------------------------------
// Timestamped message delay queue assertion macros
// Shared assertion forms for the checker of the delay queue.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_MESSAGE_DELAY_QUEUE_MACROS_SVH
`define TIMESTAMPED_MESSAGE_DELAY_QUEUE_MACROS_SVH

// Property checked on each clock edge outside of reset.
`define TMDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on each clock edge, reset included.
`define TMDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/tmdq_pkg.sv
// ----------------------------------------------------------------------------
// Delay queue package
// Types, codes and defaults shared by the delay queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package tmdq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS         = 16;

  localparam logic [1:0] MODE_MESSAGE = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESET   = 2'd2;

  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_DROPPED  = 1'b1;

  typedef struct packed {
    logic [31:0] rel_time;
    logic [2:0]  msg_type;
    logic [31:0] msg_value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_INS_RD,
    ST_INS_CHK,
    ST_DRN_RD,
    ST_DRN_CHK,
    ST_DRN_FIN
  } state_e;

endpackage

`default_nettype wire

>>> rtl/tmdq_ram.sv
// ----------------------------------------------------------------------------
// Delay queue RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmdq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/timestamped_message_delay_queue.sv
// ----------------------------------------------------------------------------
// Timestamped message delay queue
// Holds messages in a RAM ring sorted by release time and drains due ones.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i/in_ready_o) carries one command transaction:
// a message to delay, a tick poll or a queue reset. in_ready_o is high only
// while the block is idle, so one command is worked on at a time.
// A message with a zero delay passes straight through as one result; a
// message hitting a full queue comes back as one result with the dropped
// status. A tick releases every due entry in time order, up to sixteen, the
// last one flagged with out_last_o.
// A queued message is put in place by an insertion walk from the tail: each
// step reads one entry from the RAM and, when its time is later, writes it
// one slot up. A tick reads the entries from the head and stops at the first
// one not yet due. Pass-through and drop go through the emit state; reset
// mode and the unused mode are done as the command is accepted.
// The output channel has one output register; when the receiver stalls the
// walk waits in place and nothing is lost. Reset clears the queue and the
// held delay; the RAM content is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_message_delay_queue
  import tmdq_pkg::*;
#(
  parameter int QueueDepth = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [30:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [31:0]        current_time_i,
  input  wire logic [2:0]         msg_type_i,
  input  wire logic [31:0]        msg_value_i,
  input  wire logic               delay_given_i,
  input  wire logic signed [31:0] delay_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    out_status_o,
  output logic [2:0]              out_type_o,
  output logic [31:0]             out_value_o,
  output logic                    out_last_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  // Physical slot of logical position k, counted from the ring head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, k};
    if (s >= (CW + 1)'(QueueDepth)) begin
      s = s - (CW + 1)'(QueueDepth);
    end
    return s[AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [30:0]   held_q, held_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;        // insertion slot or drain position
  logic          emit_st_q, emit_st_d;
  logic [31:0]   now_q;
  logic [31:0]   rel_q;
  logic [2:0]    type_q;
  logic [31:0]   value_q;
  logic          pend_v_q, pend_v_d;
  logic [2:0]    pend_type_q, pend_type_d;
  logic [31:0]   pend_value_q, pend_value_d;

  logic          out_valid_q;
  logic          out_status_q, out_last_q;
  logic [2:0]    out_type_q;
  logic [31:0]   out_value_q;

  logic          ld;
  logic          ld_status, ld_last;
  logic [2:0]    ld_type;
  logic [31:0]   ld_value;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic          accept;
  logic          space;
  logic          zero_req;
  logic [30:0]   held_new;
  logic          due;
  logic          can_drain;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign space      = !out_valid_q || out_ready_i;
  assign zero_req   = delay_given_i && (delay_request_i == 32'sd0);
  assign due        = (ram_rdata.rel_time <= now_q);
  assign can_drain  = (idx_q < count_q) && (int'(idx_q) < MAX_RESULTS);

  // A positive delay replaces the held delay, a zero delay clears it and a
  // negative or missing one leaves it alone.
  always_comb begin
    held_new = held_q;
    if (delay_given_i) begin
      if (zero_req) begin
        held_new = '0;
      end else if (!delay_request_i[31]) begin
        held_new = delay_request_i[30:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_MESSAGE: begin
              if (zero_req || (count_q >= CW'(QueueDepth))) begin
                state_d = ST_EMIT;
              end else begin
                state_d = ST_INS_RD;
              end
            end
            MODE_TICK: state_d = ST_DRN_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: if (space) state_d = ST_IDLE;
      ST_INS_RD: begin
        if (idx_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (ram_rdata.rel_time > rel_q) begin
          state_d = ST_INS_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRN_RD: state_d = can_drain ? ST_DRN_CHK : ST_DRN_FIN;
      ST_DRN_CHK: begin
        if (!due) begin
          state_d = ST_DRN_FIN;
        end else if (!pend_v_q || space) begin
          state_d = ST_DRN_RD;
        end
      end
      ST_DRN_FIN: if (!pend_v_q || space) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM port and output register controls.
  always_comb begin
    held_d       = held_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    emit_st_d    = emit_st_q;
    pend_v_d     = pend_v_q;
    pend_type_d  = pend_type_q;
    pend_value_d = pend_value_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = phys(head_q, idx_q);
    ram_raddr    = phys(head_q, idx_q);
    ram_wdata    = '{rel_time: rel_q, msg_type: type_q, msg_value: value_q};
    ld           = 1'b0;
    ld_status    = STATUS_RELEASED;
    ld_last      = 1'b1;
    ld_type      = type_q;
    ld_value     = value_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          held_d = cfg_wdata_i;
        end
        if (accept) begin
          case (mode_i)
            MODE_MESSAGE: begin
              held_d    = held_new;
              idx_d     = count_q;
              emit_st_d = zero_req ? STATUS_RELEASED : STATUS_DROPPED;
            end
            MODE_TICK: begin
              idx_d    = '0;
              pend_v_d = 1'b0;
            end
            MODE_RESET: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        ld        = space;
        ld_status = emit_st_q;
      end
      ST_INS_RD: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_q, idx_q - 1'b1);
        end
      end
      ST_INS_CHK: begin
        ram_we = 1'b1;
        if (ram_rdata.rel_time > rel_q) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      ST_DRN_RD: ram_re = can_drain;
      ST_DRN_CHK: begin
        if (due && (!pend_v_q || space)) begin
          ld           = pend_v_q;
          ld_last      = 1'b0;
          ld_type      = pend_type_q;
          ld_value     = pend_value_q;
          pend_v_d     = 1'b1;
          pend_type_d  = ram_rdata.msg_type;
          pend_value_d = ram_rdata.msg_value;
          idx_d        = idx_q + 1'b1;
        end
      end
      ST_DRN_FIN: begin
        if (!pend_v_q || space) begin
          ld       = pend_v_q;
          ld_type  = pend_type_q;
          ld_value = pend_value_q;
          pend_v_d = 1'b0;
          head_d   = phys(head_q, idx_q);
          count_d  = count_q - idx_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    emit_st_q    <= emit_st_d;
    pend_type_q  <= pend_type_d;
    pend_value_q <= pend_value_d;
    if (accept) begin
      now_q   <= current_time_i;
      rel_q   <= current_time_i + {1'b0, held_new};
      type_q  <= msg_type_i;
      value_q <= msg_value_i;
    end
    if (ld) begin
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
      out_type_q   <= ld_type;
      out_value_q  <= ld_value;
    end
  end

  tmdq_ram #(
    .Width ($bits(entry_t)),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;
  assign out_type_o   = out_type_q;
  assign out_value_o  = out_value_q;

endmodule

`default_nettype wire

>>> rtl/tmdq_checker.sv
// ----------------------------------------------------------------------------
// Delay queue checker
// Port-level checks on the delay queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timestamped_message_delay_queue_macros.svh"

module tmdq_checker
  import tmdq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  mode_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        out_status_o,
  input wire logic [2:0]  out_type_o,
  input wire logic [31:0] out_value_o,
  input wire logic        out_last_o
);

  logic [37:0] out_bus;
  logic        msg_acc;

  assign out_bus = {out_status_o, out_type_o, out_value_o, out_last_o};
  assign msg_acc = in_valid_i && in_ready_o && (mode_i == MODE_MESSAGE);

  `TMDQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `TMDQ_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_bus), "result moved")
  `TMDQ_ASSERT(a_drop_last, out_valid_o && out_status_o |-> out_last_o, "drop not last")
  `TMDQ_ASSERT(a_msg_busy, msg_acc |=> !in_ready_o, "ready right after a message")
  `TMDQ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind timestamped_message_delay_queue tmdq_checker u_tmdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .mode_i       (mode_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_status_o (out_status_o),
  .out_type_o   (out_type_o),
  .out_value_o  (out_value_o),
  .out_last_o   (out_last_o)
);

`default_nettype wire

>>> tb/sv/timestamped_message_delay_queue_tb.sv
// ----------------------------------------------------------------------------
// Timestamped message delay queue testbench
// Drives message, tick and reset transactions with random gaps and stalls,
// and checks every released or dropped message against a predicted queue.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_message_delay_queue_tb;
  import tmdq_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now;
    logic [2:0]  mtype;
    logic [31:0] mvalue;
    logic        given;
    logic [31:0] req;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  mtype;
    logic [31:0] mvalue;
    logic        last;
  } release_t;

  // Directed table row: the command, and optionally the typed-in result.
  typedef struct {
    cmd_t     cmd;
    int       n_fixed;
    release_t fixed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_RESET;
  logic [31:0] current_time_i = '0;
  logic [2:0]  msg_type_i = '0;
  logic [31:0] msg_value_i = '0;
  logic        delay_given_i = 1'b0;
  logic signed [31:0] delay_request_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        out_status_o;
  logic [2:0]  out_type_o;
  logic [31:0] out_value_o;
  logic        out_last_o;

  timestamped_message_delay_queue u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .mode_i, .current_time_i, .msg_type_i, .msg_value_i, .delay_given_i,
    .delay_request_i, .out_valid_o, .out_ready_i, .out_status_o,
    .out_type_o, .out_value_o, .out_last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the queue, sorted by release time.
  logic [31:0] q_time [Depth];
  logic [2:0]  q_type [Depth];
  logic [31:0] q_value[Depth];
  int          q_count;
  logic [30:0] q_held;

  release_t pending_releases[$];
  int       mismatches = 0;
  longint   cycle = 0;
  bit       stall_enable = 1'b1;

  // Works out the transactions that one command releases.
  task automatic predict_command(input cmd_t c);
    int n, pos;
    logic [31:0] t;
    release_t r;
    if (c.mode == MODE_RESET) begin
      q_count = 0;
    end else if (c.mode == MODE_TICK) begin
      n = 0;
      while (n < q_count && n < MAX_RESULTS && q_time[n] <= c.now) n++;
      for (int i = 0; i < n; i++) begin
        r = '{STATUS_RELEASED, q_type[i], q_value[i], (i + 1 == n)};
        pending_releases.push_back(r);
      end
      for (int i = n; i < q_count; i++) begin
        q_time[i - n] = q_time[i];
        q_type[i - n] = q_type[i];
        q_value[i - n] = q_value[i];
      end
      q_count -= n;
    end else if (c.mode == MODE_MESSAGE) begin
      if (c.given && c.req == 32'd0) begin
        q_held = '0;
        pending_releases.push_back('{STATUS_RELEASED, c.mtype, c.mvalue, 1'b1});
        return;
      end
      if (c.given && !c.req[31]) q_held = c.req[30:0];
      if (q_count >= Depth) begin
        pending_releases.push_back('{STATUS_DROPPED, c.mtype, c.mvalue, 1'b1});
        return;
      end
      t = c.now + {1'b0, q_held};
      pos = 0;
      while (pos < q_count && q_time[pos] <= t) pos++;
      for (int i = q_count; i > pos; i--) begin
        q_time[i] = q_time[i - 1];
        q_type[i] = q_type[i - 1];
        q_value[i] = q_value[i - 1];
      end
      q_time[pos] = t;
      q_type[pos] = c.mtype;
      q_value[pos] = c.mvalue;
      q_count++;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Presents one command and returns at the edge that accepts it. Valid is
  // dropped only when a gap follows, so back-to-back commands keep it high.
  task automatic drive_command(input cmd_t c);
    int g;
    g = gap_length();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= c.mode;
    current_time_i <= c.now;
    msg_type_i <= c.mtype;
    msg_value_i <= c.mvalue;
    delay_given_i <= c.given;
    delay_request_i <= c.req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_command(input cmd_t c);
    predict_command(c);
    drive_command(c);
  endtask

  // Waits until every expected transaction has come, then lets the walk settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_initial_delay(input logic [30:0] d);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    q_held = d;
  endtask

  function automatic cmd_t random_command(input logic [31:0] base);
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.mtype = 3'($urandom_range(0, 7));
    c.mvalue = $urandom;
    c.now = base + $urandom_range(0, 50);
    c.given = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: c.req = 32'd0;
      1: c.req = $urandom | 32'h8000_0000;
      2: c.req = $urandom;
      default: c.req = $urandom_range(1, 60);
    endcase
    if (pick < 60) c.mode = MODE_MESSAGE;
    else if (pick < 92) c.mode = MODE_TICK;
    else if (pick < 97) c.mode = MODE_RESET;
    else c.mode = 2'd3;
    if (c.mode == MODE_TICK && $urandom_range(0, 9) == 0) c.now = 32'hFFFF_FFFF;
    return c;
  endfunction

  // Output side: random stalls, and each transaction checked in order.
  always @(posedge clk_i) begin
    release_t got, want;
    cycle <= cycle + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_status_o, out_type_o, out_value_o, out_last_o};
      if (pending_releases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", got);
      end else begin
        want = pending_releases.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (!stall_enable) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 29) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (cycle > CycleLimit) begin
      $display("timestamped_message_delay_queue_tb NOT OK");
      $finish;
    end
  end

  row_t rows[$];
  release_t none_r;

  initial begin
    cmd_t c;
    logic [31:0] base;
    release_t pr;
    none_r = '0;
    q_count = 0;
    q_held = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, every mode, zero/negative/absent delays,
    // equal times, wrap of the release time, and a full queue.
    rows.push_back('{'{MODE_TICK, 32'hFFFF_FFFF, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});
    rows.push_back('{'{MODE_MESSAGE, 32'd0, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'd0}, 1,
                     '{STATUS_RELEASED, 3'd7, 32'hFFFF_FFFF, 1'b1}});
    rows.push_back('{'{MODE_MESSAGE, 32'd10, 3'd1, 32'h1, 1'b1, 32'd5}, 0, none_r});
    rows.push_back('{'{MODE_MESSAGE, 32'd10, 3'd2, 32'h2, 1'b0, 32'd0}, 0, none_r});
    rows.push_back('{'{MODE_MESSAGE, 32'd10, 3'd3, 32'h3, 1'b1, 32'h8000_0000}, 0, none_r});
    rows.push_back('{'{MODE_MESSAGE, 32'hFFFF_FFFF, 3'd4, 32'h4, 1'b1, 32'h7FFF_FFFF}, 0,
                     none_r});
    rows.push_back('{'{MODE_TICK, 32'd14, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});
    rows.push_back('{'{MODE_TICK, 32'd15, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});
    rows.push_back('{'{2'd3, 32'd0, 3'd5, 32'h5, 1'b1, 32'd0}, 0, none_r});
    rows.push_back('{'{MODE_TICK, 32'hFFFF_FFFF, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});
    rows.push_back('{'{MODE_MESSAGE, 32'd0, 3'd6, 32'h6, 1'b1, 32'd100}, 0, none_r});
    rows.push_back('{'{MODE_RESET, 32'd0, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});
    for (int i = 0; i < 17; i++)
      rows.push_back('{'{MODE_MESSAGE, 32'd0, 3'(i), 32'hA000 + i, 1'b0, 32'd0},
                       (i == 16) ? 1 : 0,
                       '{STATUS_DROPPED, 3'(i), 32'hA000 + i, 1'b1}});
    rows.push_back('{'{MODE_TICK, 32'd100, 3'd0, 32'd0, 1'b0, 32'd0}, 0, none_r});

    foreach (rows[k]) begin
      predict_command(rows[k].cmd);
      if (rows[k].n_fixed != 0) begin
        // The typed-in result must agree with the prediction as well.
        pr = pending_releases.pop_back();
        if (pr !== rows[k].fixed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %p, predicted %p", k, rows[k].fixed, pr);
        end
        pending_releases.push_back(rows[k].fixed);
      end
      drive_command(rows[k].cmd);
    end

    // Random phases under several initial delay settings, extremes included.
    base = 32'hFFFF_FF00;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_initial_delay(31'd0);
        1: write_initial_delay(31'h7FFF_FFFF);
        2: write_initial_delay(31'd20);
        default: write_initial_delay(31'($urandom_range(1, 40)));
      endcase
      stall_enable = (phase != 3);
      for (int i = 0; i < 24; i++) begin
        c = random_command(base);
        send_command(c);
        base += $urandom_range(0, 8);
      end
    end
    stall_enable = 1'b1;

    wait_drained();
    if (mismatches == 0) $display("timestamped_message_delay_queue_tb OK");
    else $display("timestamped_message_delay_queue_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
